>>> hw/rtl/lge_pkg.sv
// Shared types, constants and helper functions of the life grid engine.
package lge_pkg;

   localparam int GRID_COLS = 32;
   localparam int GRID_ROWS = 32;

   localparam int CFG_W     = 6;
   localparam int COL_AW    = $clog2(GRID_COLS);
   localparam int ROW_AW    = $clog2(GRID_ROWS);
   localparam int STEP_W    = $clog2(GRID_ROWS + 2);
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] MODE_TOGGLE = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_STEP   = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 2'd1;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] cell_col;
      logic [4:0] cell_row;
   } req_type;

   typedef struct packed {
      logic [31:0] row_bits;
      logic        out_of_range;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              clear_all;
      logic              win_reset;
      logic              win_shift;
      logic              win_in_zero;
      logic              gen_wr;
      logic              tog_wr;
      logic [ROW_AW-1:0] wr_addr;
      logic [COL_AW-1:0] tog_col;
      logic              res_clear;
      logic              res_capture;
      logic              rsp_load;
      logic              rsp_oor;
   } lge_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } lge_sts_type;

   // Bit c is set when column c lies inside the active width.
   function automatic logic [GRID_COLS-1:0] col_mask(input logic [CFG_W-1:0] ncols);
      logic [GRID_COLS-1:0] m;
      m = '0;
      for (int i = 0; i < GRID_COLS; i++) begin
         m[i] = (CFG_W'(i) < ncols);
      end
      return m;
   endfunction

endpackage

>>> hw/rtl/lge_ctrl.sv
// Controller state machine that sequences toggle, clear, generation and row read transactions.
module lge_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lge_pkg::req_type    req_data,
   input  logic [5:0]          eff_cols,
   input  logic [5:0]          eff_rows,
   input  lge_pkg::lge_sts_type sts,
   output lge_pkg::lge_cmd_type cmd
);
   import lge_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ACCESS = 2'd1;
   localparam logic [1:0] ST_GEN    = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [COL_AW-1:0] col_ff, col_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic              oor_ff, oor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] wr_step;
   logic [STEP_W-1:0] end_step;
   logic              col_ok;
   logic              row_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign wr_step   = step_ff - STEP_W'(2);
   assign end_step  = STEP_W'(eff_rows) + STEP_W'(1);
   assign col_ok    = (CFG_W'(req_data.cell_col) < eff_cols);
   assign row_ok    = (CFG_W'(req_data.cell_row) < eff_rows);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      oor_in   = oor_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_data.mode;
               col_in        = req_data.cell_col;
               row_in        = req_data.cell_row;
               oor_in        = 1'b0;
               cmd.res_clear = 1'b1;
               case (req_data.mode)
                  MODE_TOGGLE: begin
                     if (col_ok && row_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = req_data.cell_row;
                        state_in    = ST_ACCESS;
                     end else begin
                        oor_in   = 1'b1;
                        state_in = ST_DONE;
                     end
                  end
                  MODE_CLEAR: begin
                     cmd.clear_all = 1'b1;
                     state_in      = ST_DONE;
                  end
                  MODE_STEP: begin
                     cmd.win_reset = 1'b1;
                     step_in       = '0;
                     state_in      = (eff_rows == '0) ? ST_DONE : ST_GEN;
                  end
                  default: begin
                     if (row_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = req_data.cell_row;
                        state_in    = ST_ACCESS;
                     end else begin
                        oor_in   = 1'b1;
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            if (mode_ff == MODE_TOGGLE) begin
               cmd.tog_wr  = 1'b1;
               cmd.wr_addr = row_ff;
               cmd.tog_col = col_ff;
            end else begin
               cmd.res_capture = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_GEN: begin
            cmd.rd_en   = (step_ff < STEP_W'(eff_rows));
            cmd.rd_addr = step_ff[ROW_AW-1:0];
            if (step_ff != '0) begin
               cmd.win_shift   = 1'b1;
               cmd.win_in_zero = (step_ff > STEP_W'(eff_rows));
            end
            if (step_ff >= STEP_W'(2)) begin
               cmd.gen_wr  = 1'b1;
               cmd.wr_addr = wr_step[ROW_AW-1:0];
            end
            if (step_ff == end_step) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            cmd.rsp_oor = oor_ff;
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         oor_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         oor_ff   <= oor_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
   end

endmodule

>>> hw/rtl/lge_datapath.sv
// Datapath with the grid memory, the three-row window, the life rule and the result register.
module lge_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lge_pkg::lge_cmd_type cmd,
   input  logic [5:0]           eff_cols,
   output lge_pkg::lge_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lge_pkg::rsp_type     rsp_data
);
   import lge_pkg::*;

   logic [GRID_COLS-1:0] grid_mem_ff [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [GRID_COLS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [GRID_COLS-1:0] win_prev_ff, win_prev_in;
   logic [GRID_COLS-1:0] win_cur_ff, win_cur_in;
   logic [GRID_COLS-1:0] res_bits_ff, res_bits_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [GRID_COLS-1:0] cmask;
   logic [GRID_COLS-1:0] rd_row;
   logic [GRID_COLS-1:0] incoming;
   logic [GRID_COLS-1:0] gen_row;
   logic [GRID_COLS-1:0] wr_data;
   logic                 wr_en;

   assign cmask    = col_mask(eff_cols);
   assign rd_row   = rd_valid_ff ? rd_data_ff : '0;
   assign incoming = cmd.win_in_zero ? '0 : rd_row;
   assign wr_en    = cmd.gen_wr | cmd.tog_wr;
   assign wr_data  = cmd.gen_wr ? gen_row : (rd_row ^ (GRID_COLS'(1) << cmd.tog_col));

   // Cells outside the active area count as dead and keep their old value.
   always_comb begin
      logic [GRID_COLS+1:0] pp;
      logic [GRID_COLS+1:0] cp;
      logic [GRID_COLS+1:0] np;
      logic [GRID_COLS-1:0] nxt;
      logic [3:0]           cnt;
      pp  = {1'b0, win_prev_ff & cmask, 1'b0};
      cp  = {1'b0, win_cur_ff & cmask, 1'b0};
      np  = {1'b0, incoming & cmask, 1'b0};
      nxt = '0;
      for (int i = 0; i < GRID_COLS; i++) begin
         cnt = 4'(pp[i]) + 4'(pp[i+1]) + 4'(pp[i+2]) + 4'(cp[i]) + 4'(cp[i+2])
             + 4'(np[i]) + 4'(np[i+1]) + 4'(np[i+2]);
         nxt[i] = (cnt == 4'd3) || (cp[i+1] && (cnt == 4'd2));
      end
      gen_row = (nxt & cmask) | (win_cur_ff & ~cmask);
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.clear_all) begin
         row_valid_in = '0;
      end else if (wr_en) begin
         row_valid_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_comb begin
      win_prev_in = win_prev_ff;
      win_cur_in  = win_cur_ff;
      if (cmd.win_reset) begin
         win_prev_in = '0;
         win_cur_in  = '0;
      end else if (cmd.win_shift) begin
         win_prev_in = win_cur_ff;
         win_cur_in  = incoming;
      end
   end

   always_comb begin
      res_bits_in = res_bits_ff;
      if (cmd.res_clear) begin
         res_bits_in = '0;
      end else if (cmd.res_capture) begin
         res_bits_in = rd_row & cmask;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.row_bits     = 32'(res_bits_ff);
         rsp_data_in.out_of_range = cmd.rsp_oor;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem_ff[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= grid_mem_ff[cmd.rd_addr];
         rd_valid_ff <= row_valid_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_prev_ff <= win_prev_in;
      win_cur_ff  <= win_cur_in;
      res_bits_ff <= res_bits_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.rsp_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

>>> hw/rtl/life_grid_engine.sv
// Top level of the life grid engine: size registers, controller and datapath.
//
// The engine holds a 32 by 32 grid of cells and takes one transaction at a time. With the
// result register free, an in-range toggle or row read first reads its row, then writes the
// toggled row or captures the row, and then presents its result. A clear, an out-of-range
// toggle or read, and a generation with no active rows go straight to presenting the result.
// A generation sweeps the active rows. Its time is set by the sweep, which reads one row per
// cycle through the single read port of the grid memory and writes each new row once that row
// has passed through the read register and into the middle row of the window. Sizes above 32
// count as 32. A result sits in an output register, so the next transaction is accepted while
// it waits. A transaction that finishes while that register is still full stalls until the
// register drains.
// The user must write the active size registers only while the engine is idle; the engine
// itself does not enforce this.
module life_grid_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lge_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lge_pkg::rsp_type         rsp_data,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [5:0]               csr_wr_data
);
   import lge_pkg::*;

   logic [CFG_W-1:0] active_cols_ff, active_cols_in;
   logic [CFG_W-1:0] active_rows_ff, active_rows_in;
   logic [CFG_W-1:0] eff_cols;
   logic [CFG_W-1:0] eff_rows;
   lge_cmd_type      cmd;
   lge_sts_type      sts;

   always_comb begin
      active_cols_in = active_cols_ff;
      active_rows_in = active_rows_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_COLS: active_cols_in = csr_wr_data;
            CSR_ACTIVE_ROWS: active_rows_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= CFG_W'(GRID_COLS);
         active_rows_ff <= CFG_W'(GRID_ROWS);
      end else begin
         active_cols_ff <= active_cols_in;
         active_rows_ff <= active_rows_in;
      end
   end

   assign eff_cols = (active_cols_ff > CFG_W'(GRID_COLS)) ? CFG_W'(GRID_COLS) : active_cols_ff;
   assign eff_rows = (active_rows_ff > CFG_W'(GRID_ROWS)) ? CFG_W'(GRID_ROWS) : active_rows_ff;

   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .eff_cols  (eff_cols),
      .eff_rows  (eff_rows),
      .sts       (sts),
      .cmd       (cmd)
   );

   lge_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .eff_cols  (eff_cols),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/life_grid_engine_test.sv
// Self-checking testbench of the life grid engine: a directed table, then random phases.
module life_grid_engine_test;
   import lge_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 188;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_REPORTS     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic {STIM_ITEM, STIM_CSR} stim_kind_type;

   typedef struct packed {
      stim_kind_type        kind;
      req_type              req;
      logic                 typed;
      rsp_type              rsp;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CFG_W-1:0]     csr_val;
   } stim_row_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CFG_W-1:0]     csr_wr_data = '0;

   logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
   logic [CFG_W-1:0]     pred_cols;
   logic [CFG_W-1:0]     pred_rows;
   rsp_type              awaited_results [$];
   rsp_type              want_rsp;
   stim_row_type         directed_rows [$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   int  hold_left      = 0;
   logic hold_pending  = 1'b0;

   always #2 clock = ~clock;

   life_grid_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   function automatic int clamp_size(input logic [CFG_W-1:0] v, input int limit);
      return (int'(v) > limit) ? limit : int'(v);
   endfunction

   function automatic rsp_type predict_grid_op(input req_type r);
      rsp_type              res;
      logic [GRID_COLS-1:0] prev [GRID_ROWS];
      logic [GRID_COLS-1:0] mask;
      int                   nc;
      int                   nr;
      int                   cnt;
      res = '0;
      nc  = clamp_size(pred_cols, GRID_COLS);
      nr  = clamp_size(pred_rows, GRID_ROWS);
      case (r.mode)
         MODE_TOGGLE: begin
            if (int'(r.cell_col) < nc && int'(r.cell_row) < nr) begin
               life_grid[r.cell_row][r.cell_col] = ~life_grid[r.cell_row][r.cell_col];
            end else begin
               res.out_of_range = 1'b1;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < GRID_ROWS; i++) life_grid[i] = '0;
         end
         MODE_STEP: begin
            prev = life_grid;
            for (int rr = 0; rr < nr; rr++) begin
               for (int cc = 0; cc < nc; cc++) begin
                  cnt = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && rr + dr >= 0 && rr + dr < nr &&
                            cc + dc >= 0 && cc + dc < nc && prev[rr + dr][cc + dc]) begin
                           cnt++;
                        end
                     end
                  end
                  life_grid[rr][cc] = prev[rr][cc] ? (cnt == 2 || cnt == 3) : (cnt == 3);
               end
            end
         end
         default: begin
            if (int'(r.cell_row) < nr) begin
               for (int i = 0; i < GRID_COLS; i++) mask[i] = (i < nc);
               res.row_bits = life_grid[r.cell_row] & mask;
            end else begin
               res.out_of_range = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   function automatic void add_item(input logic [1:0] mode, input int col, input int row,
                                    input int typed, input logic [31:0] bits,
                                    input int oor);
      stim_row_type s;
      s                  = '0;
      s.kind             = STIM_ITEM;
      s.req.mode         = mode;
      s.req.cell_col     = col[4:0];
      s.req.cell_row     = row[4:0];
      s.typed            = typed[0];
      s.rsp.row_bits     = bits;
      s.rsp.out_of_range = oor[0];
      directed_rows.push_back(s);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      stim_row_type s;
      s         = '0;
      s.kind    = STIM_CSR;
      s.csr_idx = idx;
      s.csr_val = val[CFG_W-1:0];
      directed_rows.push_back(s);
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s: expected row_bits=%h out_of_range=%b, got row_bits=%h out_of_range=%b",
                  what, want.row_bits, want.out_of_range, got.row_bits, got.out_of_range);
      end
   endtask

   task automatic send_req(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = predict_grid_op(r);
      awaited_results.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_ACTIVE_COLS: pred_cols = val;
         CSR_ACTIVE_ROWS: pred_rows = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("transaction with none expected", '0, rsp_data);
         end else begin
            want_rsp = awaited_results.pop_front();
            if (rsp_data.row_bits !== want_rsp.row_bits) begin
               note_mismatch("row_bits", want_rsp, rsp_data);
            end
            if (rsp_data.out_of_range !== want_rsp.out_of_range) begin
               note_mismatch("out_of_range", want_rsp, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int           phase_cols [PHASES];
      int           phase_rows [PHASES];
      int           idle_pct [4];
      int           stall_pct [4];
      int           nc;
      int           nr;
      int           w;
      req_type      r;
      stim_row_type s;

      phase_cols = '{32, 63, 7, 1, 32, 5, 40, 32};
      phase_rows = '{32, 33, 9, 32, 1, 3, 63, 20};
      idle_pct   = '{0, 64, 0, 38};
      stall_pct  = '{0, 0, 64, 38};

      for (int i = 0; i < GRID_ROWS; i++) life_grid[i] = '0;
      pred_cols = 6'd32;
      pred_rows = 6'd32;

      add_item(MODE_READ,    0,  0, 1, 32'h0, 0);
      add_item(MODE_TOGGLE,  0,  0, 1, 32'h0, 0);
      add_item(MODE_TOGGLE, 31, 31, 1, 32'h0, 0);
      add_item(MODE_READ,    0,  0, 1, 32'h1, 0);
      add_item(MODE_READ,    0, 31, 1, 32'h8000_0000, 0);
      add_item(MODE_STEP,    0,  0, 1, 32'h0, 0);
      add_item(MODE_READ,    0,  0, 1, 32'h0, 0);
      add_item(MODE_TOGGLE,  1,  5, 1, 32'h0, 0);
      add_item(MODE_TOGGLE,  2,  5, 1, 32'h0, 0);
      add_item(MODE_TOGGLE,  3,  5, 1, 32'h0, 0);
      add_item(MODE_STEP,    0,  0, 1, 32'h0, 0);
      add_item(MODE_READ,    0,  4, 0, 32'h0, 0);
      add_item(MODE_READ,    0,  5, 0, 32'h0, 0);
      add_csr(CSR_ACTIVE_COLS, 3);
      add_csr(CSR_ACTIVE_ROWS, 2);
      add_item(MODE_TOGGLE,  5,  1, 1, 32'h0, 1);
      add_item(MODE_TOGGLE,  2,  2, 1, 32'h0, 1);
      add_item(MODE_READ,    0,  2, 1, 32'h0, 1);
      add_item(MODE_TOGGLE,  2,  1, 0, 32'h0, 0);
      add_item(MODE_READ,    0,  1, 0, 32'h0, 0);
      add_item(MODE_STEP,    0,  0, 1, 32'h0, 0);
      add_csr(CSR_ACTIVE_COLS, 0);
      add_csr(CSR_ACTIVE_ROWS, 0);
      add_item(MODE_TOGGLE,  0,  0, 1, 32'h0, 1);
      add_item(MODE_READ,    0,  0, 1, 32'h0, 1);
      add_item(MODE_STEP,    0,  0, 1, 32'h0, 0);
      add_csr(CSR_ACTIVE_COLS, 63);
      add_csr(CSR_ACTIVE_ROWS, 40);
      add_item(MODE_READ,    0,  5, 0, 32'h0, 0);
      add_item(MODE_TOGGLE, 31, 31, 0, 32'h0, 0);
      add_csr(CSR_SPARE_A, 1);
      add_csr(CSR_SPARE_B, 1);
      add_item(MODE_READ,    0, 31, 0, 32'h0, 0);
      add_item(MODE_CLEAR,  31, 31, 1, 32'h0, 0);
      add_item(MODE_READ,   31, 31, 1, 32'h0, 0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         s = directed_rows[i];
         if (s.kind == STIM_CSR) begin
            wait_for_idle();
            write_size_reg(s.csr_idx, s.csr_val);
         end else begin
            send_req(s.req, s.typed, s.rsp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_for_idle();
         write_size_reg(CSR_ACTIVE_COLS, phase_cols[p][CFG_W-1:0]);
         write_size_reg(CSR_ACTIVE_ROWS, phase_rows[p][CFG_W-1:0]);
         send_idle_pct = idle_pct[p % 4];
         rsp_stall_pct = stall_pct[p % 4];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            nc = clamp_size(pred_cols, GRID_COLS);
            nr = clamp_size(pred_rows, GRID_ROWS);
            w  = $urandom_range(99);
            r.mode = (w < 3) ? MODE_CLEAR : (w < 20) ? MODE_STEP :
                     (w < 60) ? MODE_TOGGLE : MODE_READ;
            if (nc == 0 || nr == 0 || $urandom_range(9) == 0) begin
               r.cell_col = 5'($urandom_range(31));
               r.cell_row = 5'($urandom_range(31));
            end else begin
               r.cell_col = 5'($urandom_range(nc - 1));
               r.cell_row = 5'($urandom_range(nr - 1));
            end
            send_req(r, 1'b0, '0);
            if (p == 0 && i == 40) hold_pending = 1'b1;
            if (p == 0 && i == 120) wait_for_idle();
         end
      end

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
